[src/cle_pkg.sv]
// Shared package for the Content-Length extractor: codes, character constants,
// the name table and the structs for the top level, matcher and capture unit.
// No dependencies.
package cle_pkg;

  localparam int MAX_KEPT_CHARS_DEF = 13;
  localparam int NAME_LEN           = 17;
  localparam int POS_W              = 5;

  // Result status codes
  localparam logic [1:0] ST_FOUND    = 2'd0;
  localparam logic [1:0] ST_NONE     = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;

  // Capture phases
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_SKIP    = 2'd1;
  localparam logic [1:0] PH_COLLECT = 2'd2;

  // Conversion phases (atoi)
  localparam logic [1:0] CV_LEAD   = 2'd0;
  localparam logic [1:0] CV_DIGITS = 2'd1;
  localparam logic [1:0] CV_DONE   = 2'd2;

  // Name variants
  localparam logic [1:0] VAR_UPPER_L = 2'd0;  // Content-Length
  localparam logic [1:0] VAR_LOWER_L = 2'd1;  // Content-length
  localparam logic [1:0] VAR_LOWER   = 2'd2;  // content-length

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UC_C  = 8'h43;
  localparam logic [7:0] CH_LC_C  = 8'h63;
  localparam logic [7:0] CH_UC_L  = 8'h4C;
  localparam logic [7:0] CH_LC_L  = 8'h6C;

  localparam logic [POS_W-1:0] POS_FIRST_LETTER = POS_W'(2);
  localparam logic [POS_W-1:0] POS_L_LETTER     = POS_W'(10);
  localparam logic [POS_W-1:0] POS_LAST         = POS_W'(NAME_LEN - 1);

  localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
  localparam logic [31:0] INT_MAX   = 32'h7FFF_FFFF;

  // Expected byte at each name position ("\r\nContent-Length:")
  function automatic logic [7:0] name_char(input logic [POS_W-1:0] p);
    logic [7:0] c;
    case (p)
      5'd0:    c = CH_CR;
      5'd1:    c = CH_LF;
      5'd2:    c = CH_UC_C;
      5'd3:    c = 8'h6F;  // o
      5'd4:    c = 8'h6E;  // n
      5'd5:    c = 8'h74;  // t
      5'd6:    c = 8'h65;  // e
      5'd7:    c = 8'h6E;  // n
      5'd8:    c = 8'h74;  // t
      5'd9:    c = CH_MINUS;
      5'd10:   c = CH_UC_L;
      5'd11:   c = 8'h65;  // e
      5'd12:   c = 8'h6E;  // n
      5'd13:   c = 8'h67;  // g
      5'd14:   c = 8'h74;  // t
      5'd15:   c = 8'h68;  // h
      5'd16:   c = 8'h3A;  // :
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

  // Signed value from a saturated magnitude
  function automatic logic [31:0] final_value(input logic neg, input logic [31:0] mag);
    logic [31:0] v;
    if (neg) begin
      v = 32'd0 - mag;
    end else if (mag > INT_MAX) begin
      v = INT_MAX;
    end else begin
      v = mag;
    end
    return v;
  endfunction

  typedef struct packed {
    logic       fire;
    logic       last;
    logic [7:0] data;
  } step_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] variant;
  } hit_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value;
  } result_t;

endpackage

[src/cle_match.sv]
// Name matcher: tracks CR LF followed by one of the three Content-Length spellings.
// Depends on cle_pkg.
module cle_match (
  input  logic          clk,
  input  logic          rst_n,
  input  cle_pkg::step_t step,
  output cle_pkg::hit_t  hit
);

  logic [cle_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [1:0]                seen_r, seen_nxt;

  always_comb begin
    logic adv;
    adv      = 1'b0;
    seen_nxt = seen_r;
    pos_nxt  = pos_r;
    hit      = '0;
    if (pos_r == cle_pkg::POS_FIRST_LETTER) begin
      if (step.data == cle_pkg::CH_UC_C) begin
        seen_nxt = cle_pkg::VAR_UPPER_L;
        adv      = 1'b1;
      end else if (step.data == cle_pkg::CH_LC_C) begin
        seen_nxt = cle_pkg::VAR_LOWER;
        adv      = 1'b1;
      end
    end else if (pos_r == cle_pkg::POS_L_LETTER) begin
      if (step.data == cle_pkg::CH_UC_L && seen_r == cle_pkg::VAR_UPPER_L) begin
        adv = 1'b1;
      end else if (step.data == cle_pkg::CH_LC_L) begin
        seen_nxt = (seen_r == cle_pkg::VAR_UPPER_L) ? cle_pkg::VAR_LOWER_L
                                                     : cle_pkg::VAR_LOWER;
        adv      = 1'b1;
      end
    end else if (step.data == cle_pkg::name_char(pos_r)) begin
      adv = 1'b1;
    end

    if (!adv) begin
      // a CR can always open a new match
      pos_nxt = (step.data == cle_pkg::CH_CR) ? cle_pkg::POS_W'(1) : '0;
    end else if (pos_r == cle_pkg::POS_LAST) begin
      pos_nxt     = '0;
      hit.valid   = step.fire;
      hit.variant = seen_nxt;
    end else begin
      pos_nxt = pos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      seen_r <= '0;
    end else if (step.fire) begin
      if (step.last) begin
        pos_r  <= '0;
        seen_r <= '0;
      end else begin
        pos_r  <= pos_nxt;
        seen_r <= seen_nxt;
      end
    end
  end

endmodule

[src/cle_capture.sv]
// Value capture and atoi conversion, per-variant result table and final selection.
// Depends on cle_pkg; takes the match hit from cle_match.
module cle_capture #(
  parameter int MAX_KEPT_CHARS = cle_pkg::MAX_KEPT_CHARS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cle_pkg::step_t   step,
  input  cle_pkg::hit_t    hit,
  output cle_pkg::result_t res
);

  localparam int KW = $clog2(MAX_KEPT_CHARS + 1);

  logic [1:0]    phase_r, phase_nxt;
  logic [1:0]    cvar_r, cvar_nxt;
  logic [KW-1:0] kept_r, kept_nxt;
  logic [1:0]    conv_r, conv_nxt;
  logic          neg_r, neg_nxt;
  logic [31:0]   run_r, run_nxt;
  logic [2:0]    found_r, found_nxt;
  logic [2:0]    vstat_r, vstat_nxt;
  logic [31:0]   vval_r [3];
  logic [31:0]   vval_nxt [3];

  always_comb begin
    logic        is_digit;
    logic        fin;
    logic        fin_err;
    logic [35:0] prod;
    logic [1:0]  wvar;
    logic        wneg;
    logic [31:0] wrun;

    phase_nxt = phase_r;
    cvar_nxt  = cvar_r;
    kept_nxt  = kept_r;
    conv_nxt  = conv_r;
    neg_nxt   = neg_r;
    run_nxt   = run_r;
    found_nxt = found_r;
    vstat_nxt = vstat_r;
    for (int i = 0; i < 3; i++) vval_nxt[i] = vval_r[i];

    is_digit = (step.data >= cle_pkg::CH_ZERO) && (step.data <= cle_pkg::CH_NINE);
    prod     = {1'b0, run_r, 3'b000} + {3'b000, run_r, 1'b0}
             + {32'd0, step.data[3:0] - cle_pkg::CH_ZERO[3:0]};
    fin      = 1'b0;
    fin_err  = 1'b0;

    case (phase_r)
      cle_pkg::PH_SKIP: phase_nxt = cle_pkg::PH_COLLECT;
      cle_pkg::PH_COLLECT: begin
        if (step.data == cle_pkg::CH_CR || step.data == cle_pkg::CH_LF ||
            step.data == cle_pkg::CH_NUL) begin
          fin = 1'b1;
        end else if (step.data != cle_pkg::CH_SPACE) begin
          if (kept_r >= KW'(MAX_KEPT_CHARS)) begin
            fin     = 1'b1;
            fin_err = 1'b1;
          end else begin
            kept_nxt = kept_r + 1'b1;
            case (conv_r)
              cle_pkg::CV_LEAD: begin
                if (step.data == cle_pkg::CH_PLUS || step.data == cle_pkg::CH_MINUS) begin
                  neg_nxt  = (step.data == cle_pkg::CH_MINUS);
                  conv_nxt = cle_pkg::CV_DIGITS;
                end else if (is_digit) begin
                  run_nxt  = {28'd0, step.data[3:0]};
                  conv_nxt = cle_pkg::CV_DIGITS;
                end else if (step.data != cle_pkg::CH_TAB && step.data != cle_pkg::CH_VT &&
                             step.data != cle_pkg::CH_FF) begin
                  conv_nxt = cle_pkg::CV_DONE;
                end
              end
              cle_pkg::CV_DIGITS: begin
                if (is_digit) begin
                  run_nxt = (prod > {4'd0, cle_pkg::MAG_LIMIT}) ? cle_pkg::MAG_LIMIT
                                                               : prod[31:0];
                end else begin
                  conv_nxt = cle_pkg::CV_DONE;
                end
              end
              default: ;
            endcase
          end
        end
      end
      default: ;
    endcase

    if (fin) begin
      for (int i = 0; i < 3; i++) begin
        if (cvar_r == 2'(i)) begin
          vstat_nxt[i] = fin_err;
          vval_nxt[i]  = fin_err ? 32'd0 : cle_pkg::final_value(neg_r, run_r);
        end
      end
      phase_nxt = cle_pkg::PH_IDLE;
      cvar_nxt  = '0;
      kept_nxt  = '0;
      conv_nxt  = cle_pkg::CV_LEAD;
      neg_nxt   = 1'b0;
      run_nxt   = '0;
    end

    // first occurrence of a variant opens a new capture
    if (hit.valid) begin
      for (int i = 0; i < 3; i++) begin
        if (hit.variant == 2'(i) && !found_r[i]) begin
          found_nxt[i] = 1'b1;
          phase_nxt    = cle_pkg::PH_SKIP;
          cvar_nxt     = hit.variant;
          kept_nxt     = '0;
          conv_nxt     = cle_pkg::CV_LEAD;
          neg_nxt      = 1'b0;
          run_nxt      = '0;
        end
      end
    end

    // close an open capture at the end of the header
    wvar = cvar_nxt;
    wneg = neg_nxt;
    wrun = run_nxt;
    if (step.last && phase_nxt != cle_pkg::PH_IDLE) begin
      for (int i = 0; i < 3; i++) begin
        if (wvar == 2'(i)) begin
          vstat_nxt[i] = 1'b0;
          vval_nxt[i]  = cle_pkg::final_value(wneg, wrun);
        end
      end
    end

    res.status = cle_pkg::ST_NONE;
    res.value  = '0;
    if (found_nxt[0]) begin
      res.status = vstat_nxt[0] ? cle_pkg::ST_TOO_LONG : cle_pkg::ST_FOUND;
      res.value  = vstat_nxt[0] ? 32'd0 : vval_nxt[0];
    end else if (found_nxt[1]) begin
      res.status = vstat_nxt[1] ? cle_pkg::ST_TOO_LONG : cle_pkg::ST_FOUND;
      res.value  = vstat_nxt[1] ? 32'd0 : vval_nxt[1];
    end else if (found_nxt[2]) begin
      res.status = vstat_nxt[2] ? cle_pkg::ST_TOO_LONG : cle_pkg::ST_FOUND;
      res.value  = vstat_nxt[2] ? 32'd0 : vval_nxt[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= cle_pkg::PH_IDLE;
      cvar_r  <= '0;
      kept_r  <= '0;
      conv_r  <= cle_pkg::CV_LEAD;
      neg_r   <= 1'b0;
      run_r   <= '0;
      found_r <= '0;
      vstat_r <= '0;
      for (int i = 0; i < 3; i++) vval_r[i] <= '0;
    end else if (step.fire) begin
      if (step.last) begin
        phase_r <= cle_pkg::PH_IDLE;
        cvar_r  <= '0;
        kept_r  <= '0;
        conv_r  <= cle_pkg::CV_LEAD;
        neg_r   <= 1'b0;
        run_r   <= '0;
        found_r <= '0;
        vstat_r <= '0;
        for (int i = 0; i < 3; i++) vval_r[i] <= '0;
      end else begin
        phase_r <= phase_nxt;
        cvar_r  <= cvar_nxt;
        kept_r  <= kept_nxt;
        conv_r  <= conv_nxt;
        neg_r   <= neg_nxt;
        run_r   <= run_nxt;
        found_r <= found_nxt;
        vstat_r <= vstat_nxt;
        for (int i = 0; i < 3; i++) vval_r[i] <= vval_nxt[i];
      end
    end
  end

endmodule

[src/content_length_extractor.sv]
// Content-Length extractor, top level. A byte is registered at input, then
// processed into the result register; the last byte's result is loaded there
// when no earlier result waits to be taken. One byte per cycle, set by
// the single pass of matcher and capture logic between the two registers, while
// no last byte waits. Reset (rst_n, synchronous, active low) clears the matcher,
// capture state and result table; every last byte returns it there.
module content_length_extractor #(
  parameter int MAX_KEPT_CHARS = cle_pkg::MAX_KEPT_CHARS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_header_byte,
  input  logic               in_last_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_length_value
);

  // Input stage: one byte held for processing
  logic       stg_v_r, stg_v_nxt;
  logic [7:0] stg_byte_r;
  logic       stg_last_r;

  // Result register
  logic        out_v_r, out_v_nxt;
  logic [1:0]  out_status_r;
  logic [31:0] out_value_r;

  logic             out_free;
  logic             fire;
  cle_pkg::step_t   step;
  cle_pkg::hit_t    hit;
  cle_pkg::result_t res;

  // Only a last byte needs room in the result register; all other bytes
  // move through regardless of the output side.
  assign out_free = !out_v_r || out_ready;
  assign fire     = stg_v_r && (!stg_last_r || out_free);
  assign in_ready = !stg_v_r || fire;

  assign step.fire = fire;
  assign step.last = stg_last_r;
  assign step.data = stg_byte_r;

  cle_match u_match (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .hit   (hit)
  );

  cle_capture #(
    .MAX_KEPT_CHARS (MAX_KEPT_CHARS)
  ) u_capture (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .hit   (hit),
    .res   (res)
  );

  always_comb begin
    stg_v_nxt = stg_v_r;
    if (in_valid && in_ready) begin
      stg_v_nxt = 1'b1;
    end else if (fire) begin
      stg_v_nxt = 1'b0;
    end

    out_v_nxt = out_v_r;
    if (fire && stg_last_r) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      stg_v_r <= stg_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_byte_r <= in_header_byte;
      stg_last_r <= in_last_byte;
    end
    if (fire && stg_last_r) begin
      out_status_r <= res.status;
      out_value_r  <= res.value;
    end
  end

  assign out_valid        = out_v_r;
  assign out_status       = out_status_r;
  assign out_length_value = out_value_r;

  // A byte that is not the last never waits on the output side.
  assert property (@(posedge clk) disable iff (!rst_n)
    (stg_v_r && !stg_last_r) |-> in_ready)
    else $error("non-final byte stalled");

  // A result only appears after a last-byte transaction was processed.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(fire && stg_last_r))
    else $error("result without a final byte");

  // Processing the last byte always yields a result in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (fire && stg_last_r) |=> out_v_r)
    else $error("final byte produced no result");

  // Length is zero unless a field was found.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_status_r != cle_pkg::ST_FOUND) |-> (out_value_r == 32'd0))
    else $error("nonzero length with error status");

endmodule
